>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// No dependencies; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define RSCH_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RSCH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define RSCH_ASSERT(lbl, cond, msg)
`define RSCH_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> sv/rsch_pkg.sv
// Types and constants for the ray/sphere closest-hit block.
// No dependencies.
package rsch_pkg;
  localparam int COORD_W   = 32;
  localparam int RAD_W     = 31;
  localparam int DIR_W     = 16;
  localparam int DIFF_W    = 33;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 66;
  localparam int B_W       = 51;
  localparam int Q_W       = 66;
  localparam int P_W       = 102;
  localparam int ROOT_W    = 51;
  localparam int REM_W     = 53;
  localparam int ROOT_SUM_W = 53;
  localparam int DIR_FRAC  = 14;
  localparam int TQ_W      = ROOT_SUM_W - DIR_FRAC;
  localparam int T_W       = 38;
  localparam int DIST_W    = 31;
  localparam int EPS_W     = 12;
  localparam int COUNT_W   = 5;
  localparam int IDX_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd10;
  localparam logic [EPS_W-1:0] EPS_RESET = 12'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_SPHERE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HIT      = 1'd1;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CAST = 1'b1;

  typedef struct packed {
    logic [RAD_W-1:0]   rad;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COORD_W-1:0] cz;
  } sphere_t;

  typedef struct packed {
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [COORD_W-1:0] oz;
    logic [DIR_W-1:0]   dx;
    logic [DIR_W-1:0]   dy;
    logic [DIR_W-1:0]   dz;
  } ray_t;

  typedef struct packed {
    logic           done;
    logic           hit;
    logic [T_W-1:0] t;
  } ev_res_t;
endpackage

>>> sv/rsch_sphere_mem.sv
// Sphere table: one write port, one read port, registered read data.
// Depends on rsch_pkg.
module rsch_sphere_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  rsch_pkg::sphere_t wdata,
  input  logic [AW-1:0]    raddr,
  output rsch_pkg::sphere_t rdata
);
  import rsch_pkg::*;

  sphere_t mem [DEPTH];
  sphere_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

>>> sv/rsch_sqrt.sv
// Integer square root, restoring, one result bit per cycle.
// Depends on rsch_pkg.
module rsch_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [rsch_pkg::P_W-1:0]    radicand,
  output logic              done,
  output logic [rsch_pkg::ROOT_W-1:0] root
);
  import rsch_pkg::*;

  localparam int SH_W  = REM_W + 2;
  localparam int CNT_W = $clog2(ROOT_W);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [P_W-1:0]   rad_r;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [SH_W-1:0]  rem_sh, trial, diff;
  logic             ge;

  always_comb begin
    rem_sh   = {rem_r, rad_r[P_W-1 -: 2]};
    trial    = {2'b00, root_r, 2'b01};
    ge       = (rem_sh >= trial);
    diff     = rem_sh - trial;
    rem_nxt  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    root_nxt = {root_r[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= CNT_W'(ROOT_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[P_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

>>> sv/rsch_eval.sv
// Per-sphere test: shared multiplier sequence, discriminant, root select.
// Depends on rsch_pkg and rsch_sqrt.
module rsch_eval (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  rsch_pkg::sphere_t      sph,
  input  rsch_pkg::ray_t         ray,
  input  logic [rsch_pkg::EPS_W-1:0] eps,
  output rsch_pkg::ev_res_t      res
);
  import rsch_pkg::*;

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_MUL  = 3'd1;
  localparam logic [2:0] E_DISC = 3'd2;
  localparam logic [2:0] E_SQRT = 3'd3;

  localparam logic [3:0] OP_NONE = 4'd0;
  localparam logic [3:0] OP_BX   = 4'd1;
  localparam logic [3:0] OP_BY   = 4'd2;
  localparam logic [3:0] OP_BZ   = 4'd3;
  localparam logic [3:0] OP_QX   = 4'd4;
  localparam logic [3:0] OP_QY   = 4'd5;
  localparam logic [3:0] OP_QZ   = 4'd6;
  localparam logic [3:0] OP_RR   = 4'd7;
  localparam logic [3:0] OP_LL   = 4'd8;
  localparam logic [3:0] OP_HL   = 4'd9;
  localparam logic [3:0] OP_HH   = 4'd10;
  localparam logic [3:0] OP_END  = 4'd11;

  logic [2:0]          st_r;
  logic [3:0]          op_r, aop_r;
  logic [DIFF_W-1:0]   d_r [3];
  logic [RAD_W-1:0]    rad_r;
  logic [PROD_W-1:0]   prod_r;
  logic                neg_r;
  logic [B_W-1:0]      b_acc_r, bmag_r;
  logic [Q_W-1:0]      q_acc_r;
  logic [P_W-1:0]      p_acc_r;
  ev_res_t             res_r;

  logic [DIFF_W-1:0]   dmag [3];
  logic [DIR_W-1:0]    dirmag [3];
  logic [DIR_W-1:0]    dir [3];
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic                mul_neg;
  logic [B_W-1:0]      prod_b;
  logic [P_W-1:0]      qs, disc;
  logic                disc_neg;
  logic                sq_start, sq_done;
  logic [ROOT_W-1:0]   sq_root;
  logic [ROOT_SUM_W-1:0] b_ext, s_ext, tn, tf;
  logic [TQ_W-1:0]     tn_q, tf_q, eps_q;
  logic                tn_ok, tf_ok;

  assign dir[0] = ray.dx;
  assign dir[1] = ray.dy;
  assign dir[2] = ray.dz;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dmag[k]   = d_r[k][DIFF_W-1] ? -d_r[k] : d_r[k];
      dirmag[k] = dir[k][DIR_W-1] ? -dir[k] : dir[k];
    end
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (op_r)
      OP_BX: begin
        mul_a = dmag[0]; mul_b = MUL_W'(dirmag[0]);
        mul_neg = d_r[0][DIFF_W-1] ^ dir[0][DIR_W-1];
      end
      OP_BY: begin
        mul_a = dmag[1]; mul_b = MUL_W'(dirmag[1]);
        mul_neg = d_r[1][DIFF_W-1] ^ dir[1][DIR_W-1];
      end
      OP_BZ: begin
        mul_a = dmag[2]; mul_b = MUL_W'(dirmag[2]);
        mul_neg = d_r[2][DIFF_W-1] ^ dir[2][DIR_W-1];
      end
      OP_QX: begin mul_a = dmag[0]; mul_b = dmag[0]; end
      OP_QY: begin mul_a = dmag[1]; mul_b = dmag[1]; end
      OP_QZ: begin mul_a = dmag[2]; mul_b = dmag[2]; end
      OP_RR: begin mul_a = MUL_W'(rad_r); mul_b = MUL_W'(rad_r); end
      OP_LL: begin mul_a = MUL_W'(bmag_r[31:0]); mul_b = MUL_W'(bmag_r[31:0]); end
      OP_HL: begin mul_a = MUL_W'(bmag_r[B_W-1:32]); mul_b = MUL_W'(bmag_r[31:0]); end
      OP_HH: begin
        mul_a = MUL_W'(bmag_r[B_W-1:32]); mul_b = MUL_W'(bmag_r[B_W-1:32]);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_comb begin
    prod_b   = neg_r ? -prod_r[B_W-1:0] : prod_r[B_W-1:0];
    qs       = P_W'(q_acc_r) << (2 * DIR_FRAC);
    disc_neg = (p_acc_r < qs);
    disc     = p_acc_r - qs;
    sq_start = (st_r == E_DISC) && !disc_neg;
    b_ext    = ROOT_SUM_W'($signed(b_acc_r));
    s_ext    = ROOT_SUM_W'(sq_root);
    tn       = b_ext - s_ext;
    tf       = b_ext + s_ext;
    tn_q     = tn[ROOT_SUM_W-1:DIR_FRAC];
    tf_q     = tf[ROOT_SUM_W-1:DIR_FRAC];
    eps_q    = TQ_W'(eps);
    tn_ok    = $signed(tn_q) > $signed(eps_q);
    tf_ok    = $signed(tf_q) > $signed(eps_q);
  end

  rsch_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (disc),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= E_IDLE;
      op_r     <= OP_NONE;
      aop_r    <= OP_NONE;
      res_r    <= '0;
    end else begin
      case (st_r)
        E_IDLE: begin
          res_r.done <= 1'b0;
          aop_r      <= OP_NONE;
          if (start) begin
            op_r <= OP_BX;
            st_r <= E_MUL;
          end
        end
        E_MUL: begin
          res_r.done <= 1'b0;
          aop_r      <= op_r;
          op_r       <= op_r + 1'b1;
          if (op_r == OP_END) begin
            st_r <= E_DISC;
          end
        end
        E_DISC: begin
          aop_r <= OP_NONE;
          if (disc_neg) begin
            res_r.done <= 1'b1;
            res_r.hit  <= 1'b0;
            st_r       <= E_IDLE;
          end else begin
            res_r.done <= 1'b0;
            st_r       <= E_SQRT;
          end
        end
        E_SQRT: begin
          if (sq_done) begin
            res_r.done <= 1'b1;
            res_r.hit  <= tn_ok || tf_ok;
            res_r.t    <= tn_ok ? tn_q[T_W-1:0] : tf_q[T_W-1:0];
            st_r       <= E_IDLE;
          end else begin
            res_r.done <= 1'b0;
          end
        end
        default: begin
          res_r.done <= 1'b0;
          st_r       <= E_IDLE;
        end
      endcase
    end
  end

  // datapath: the product of one op is accumulated in the cycle after it issues
  always_ff @(posedge clk) begin
    if (st_r == E_IDLE && start) begin
      d_r[0]  <= {sph.cx[COORD_W-1], sph.cx} - {ray.ox[COORD_W-1], ray.ox};
      d_r[1]  <= {sph.cy[COORD_W-1], sph.cy} - {ray.oy[COORD_W-1], ray.oy};
      d_r[2]  <= {sph.cz[COORD_W-1], sph.cz} - {ray.oz[COORD_W-1], ray.oz};
      rad_r   <= sph.rad;
      b_acc_r <= '0;
      q_acc_r <= '0;
      p_acc_r <= '0;
    end else begin
      case (aop_r)
        OP_BX, OP_BY, OP_BZ: b_acc_r <= b_acc_r + prod_b;
        OP_QX, OP_QY, OP_QZ: q_acc_r <= q_acc_r + prod_r;
        OP_RR: p_acc_r <= p_acc_r + (P_W'(prod_r) << (2 * DIR_FRAC));
        OP_LL: p_acc_r <= p_acc_r + P_W'(prod_r);
        OP_HL: p_acc_r <= p_acc_r + (P_W'(prod_r) << 33);
        OP_HH: p_acc_r <= p_acc_r + (P_W'(prod_r) << 64);
        default: begin
          p_acc_r <= p_acc_r;
        end
      endcase
    end
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    neg_r  <= mul_neg;
    if (op_r == OP_RR) begin
      bmag_r <= b_acc_r[B_W-1] ? -b_acc_r : b_acc_r;
    end
  end

  assign res = res_r;
endmodule

>>> sv/ray_sphere_closest_hit.sv
// Ray against sphere table, closest hit: handshakes, config, sphere sequencing
// and best-hit tracking. Depends on rsch_pkg, rsch_sphere_mem, rsch_eval, assert_macros.svh.
// Steps to out_tvalid: a load goes straight to finish; a cast per tested sphere takes table read,
// products on one 33x33 multiplier, discriminant, square root, handoff; no root if no real root.
// One item in work; the input is ready again once its result is registered, and a result
// not yet taken holds the next one. rst_n (sync) clears control and config, not the table.
`include "assert_macros.svh"
module ray_sphere_closest_hit #(
  parameter int MAX_SPHERES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // entry_index, entry_radius, entry_center_x/y/z, ray_origin_x/y/z,
  // ray_dir_x/y/z, zero pad
  input  logic [279:0]  in_tdata,
  // cmd
  input  logic          in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // hit_index, hit_distance, zero pad
  output logic [39:0]   out_tdata,
  // hit
  output logic          out_tuser,
  input  logic          cfg_we,
  input  logic [rsch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsch_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rsch_pkg::*;

  localparam int SLOT_W = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CNT_W  = $clog2(MAX_SPHERES + 1);
  localparam int NSLOT  = 1 << IDX_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]         st_r;
  logic [COUNT_W-1:0] count_r;
  logic [EPS_W-1:0]   eps_r;
  ray_t               ray_r;
  logic [CNT_W-1:0]   idx_r, n_r, n_cast;
  logic               found_r;
  logic [T_W-1:0]     best_t_r;
  logic [SLOT_W-1:0]  best_i_r;
  logic               out_tvalid_r, out_hit_r;
  logic [IDX_W-1:0]   out_idx_r;
  logic [DIST_W-1:0]  out_dist_r;

  logic               in_xfer, out_xfer, load_we, last_sph, better, fin_go;
  logic [SLOT_W-1:0]  slot_tbl [NSLOT];
  sphere_t            wr_sph, rd_sph;
  ray_t               in_ray;
  ev_res_t            ev_res;

  for (genvar j = 0; j < NSLOT; j++) begin : g_slot
    assign slot_tbl[j] = SLOT_W'(j % MAX_SPHERES);
  end

  assign in_tready = (st_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_tvalid_r && out_tready;
  assign load_we   = in_xfer && (in_tuser == CMD_LOAD);

  assign wr_sph.rad = in_tdata[34:4];
  assign wr_sph.cx  = in_tdata[66:35];
  assign wr_sph.cy  = in_tdata[98:67];
  assign wr_sph.cz  = in_tdata[130:99];
  assign in_ray.ox  = in_tdata[162:131];
  assign in_ray.oy  = in_tdata[194:163];
  assign in_ray.oz  = in_tdata[226:195];
  assign in_ray.dx  = in_tdata[242:227];
  assign in_ray.dy  = in_tdata[258:243];
  assign in_ray.dz  = in_tdata[274:259];

  always_comb begin
    if (32'(count_r) > 32'(MAX_SPHERES)) begin
      n_cast = CNT_W'(MAX_SPHERES);
    end else begin
      n_cast = CNT_W'(count_r);
    end
    last_sph = (CNT_W'(idx_r + 1'b1) == n_r);
    better   = ev_res.hit && (!found_r || (ev_res.t < best_t_r));
    fin_go   = (st_r == ST_FIN) && (!out_tvalid_r || out_tready);
  end

  // one item in flight, so table writes and reads never overlap
  rsch_sphere_mem #(
    .DEPTH (MAX_SPHERES),
    .AW    (SLOT_W)
  ) u_mem (
    .clk   (clk),
    .we    (load_we),
    .waddr (slot_tbl[in_tdata[IDX_W-1:0]]),
    .wdata (wr_sph),
    .raddr (idx_r[SLOT_W-1:0]),
    .rdata (rd_sph)
  );

  rsch_eval u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == ST_START),
    .sph   (rd_sph),
    .ray   (ray_r),
    .eps   (eps_r),
    .res   (ev_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
      eps_r   <= EPS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPHERE_COUNT: count_r <= cfg_wdata[COUNT_W-1:0];
        CFG_MIN_HIT:      eps_r   <= cfg_wdata[EPS_W-1:0];
        default: begin
          count_r <= count_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      found_r      <= 1'b0;
      idx_r        <= '0;
      n_r          <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (fin_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_xfer) begin
        out_tvalid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_xfer) begin
            found_r <= 1'b0;
            idx_r   <= '0;
            n_r     <= n_cast;
            if (in_tuser == CMD_LOAD || n_cast == '0) begin
              st_r <= ST_FIN;
            end else begin
              st_r <= ST_READ;
            end
          end
        end
        ST_READ:  st_r <= ST_START;
        ST_START: st_r <= ST_WAIT;
        ST_WAIT: begin
          if (ev_res.done) begin
            if (better) begin
              found_r <= 1'b1;
            end
            if (last_sph) begin
              st_r <= ST_FIN;
            end else begin
              idx_r <= idx_r + 1'b1;
              st_r  <= ST_READ;
            end
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ray_r <= in_ray;
    end
    if (st_r == ST_WAIT && ev_res.done && better) begin
      best_t_r <= ev_res.t;
      best_i_r <= idx_r[SLOT_W-1:0];
    end
    if (fin_go) begin
      out_hit_r  <= found_r;
      out_idx_r  <= found_r ? IDX_W'(best_i_r) : '0;
      if (!found_r) begin
        out_dist_r <= '0;
      end else if (best_t_r > T_W'(DIST_MAX)) begin
        out_dist_r <= DIST_MAX;
      end else begin
        out_dist_r <= best_t_r[DIST_W-1:0];
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {5'b0, out_dist_r, out_idx_r};

  `RSCH_ASSERT(a_done_in_wait, !ev_res.done || st_r == ST_WAIT, "eval result outside wait")
  `RSCH_ASSERT(a_idx_in_range, st_r != ST_READ || idx_r < n_r, "sphere index past count")
  `RSCH_ASSERT_NEXT(a_load_fin, load_we, st_r == ST_FIN, "load did not go to finish")
endmodule
